// ----- hw/rtl/paids_pkg.sv -----
// Package: sizes, operation and status codes, and chain command types for the array unit.
`default_nettype none

package paids_pkg;

	// Array geometry and field widths
	localparam int DEPTH  = 64;
	localparam int WORD_W = 32;
	localparam int CNT_W  = 7;
	localparam int IDX_W  = 6;
	localparam int FUNC_W = 3;
	localparam int STAT_W = 3;

	// Search encoder grouping
	localparam int GRP   = 8;
	localparam int GRP_W = 3;
	localparam int NGRP  = (DEPTH + GRP - 1) / GRP;

	// Operation codes on the func field
	localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd0;
	localparam logic [FUNC_W-1:0] FN_INSERT = 3'd1;
	localparam logic [FUNC_W-1:0] FN_DELETE = 3'd2;
	localparam logic [FUNC_W-1:0] FN_SEARCH = 3'd3;
	localparam logic [FUNC_W-1:0] FN_READ   = 3'd4;

	// Result status codes
	localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
	localparam logic [STAT_W-1:0] STAT_FULL     = 3'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd2;
	localparam logic [STAT_W-1:0] STAT_BADPOS   = 3'd3;
	localparam logic [STAT_W-1:0] STAT_NOTFOUND = 3'd4;

	// Per-cell load select
	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_NEW,
		CELL_LEFT,
		CELL_RIGHT,
		CELL_WRAP
	} cell_op_t;

	// Whole-chain operation
	typedef enum logic [1:0] {
		CH_NONE,
		CH_INSERT,
		CH_DELETE,
		CH_ROTATE
	} chain_op_t;

	// Command from the sequencer to the chain
	typedef struct packed {
		chain_op_t          op;
		logic [CNT_W-1:0]   pos;
		logic [CNT_W-1:0]   n;
		logic [WORD_W-1:0]  value;
		logic [WORD_W-1:0]  key;
	} chain_cmd_t;

endpackage

`default_nettype wire

// ----- hw/rtl/paids_cell.sv -----
// One storage cell of the chain: a word register with neighbor loads and a key compare.
`default_nettype none

module paids_cell (
	input  wire                          clk,
	input  paids_pkg::cell_op_t          op,
	input  wire [paids_pkg::WORD_W-1:0]  left_word,
	input  wire [paids_pkg::WORD_W-1:0]  right_word,
	input  wire [paids_pkg::WORD_W-1:0]  wrap_word,
	input  wire [paids_pkg::WORD_W-1:0]  new_word,
	input  wire [paids_pkg::WORD_W-1:0]  key,
	output logic [paids_pkg::WORD_W-1:0] word,
	output logic                         match
);
	import paids_pkg::*;

	logic [WORD_W-1:0] word_q;

	// word register, loaded from the chosen source
	always_ff @(posedge clk) begin
		case (op)
			CELL_NEW:   word_q <= new_word;
			CELL_LEFT:  word_q <= left_word;
			CELL_RIGHT: word_q <= right_word;
			CELL_WRAP:  word_q <= wrap_word;
			default:    word_q <= word_q;
		endcase
	end

	assign word  = word_q;
	assign match = (word_q == key);

endmodule

`default_nettype wire

// ----- hw/rtl/paids_chain.sv -----
// Row of storage cells with the per-cell decode of insert, delete and rotate.
`default_nettype none

module paids_chain (
	input  wire                          clk,
	input  paids_pkg::chain_cmd_t        cmd,
	output logic [paids_pkg::WORD_W-1:0] head_word,
	output logic [paids_pkg::DEPTH-1:0]  hits
);
	import paids_pkg::*;

	logic [WORD_W-1:0] words [DEPTH];
	logic [DEPTH-1:0]  eq;

	genvar i;
	generate
		for (i = 0; i < DEPTH; i++) begin : g_cell
			localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
			cell_op_t          op;
			logic [WORD_W-1:0] left_w;
			logic [WORD_W-1:0] right_w;
			logic [CNT_W-1:0]  lo;

			// neighbor taps, tied off at both ends
			if (i == 0) begin : g_lend
				assign left_w = '0;
			end else begin : g_lmid
				assign left_w = words[i-1];
			end
			if (i == DEPTH - 1) begin : g_rend
				assign right_w = '0;
			end else begin : g_rmid
				assign right_w = words[i+1];
			end

			// load select for this cell
			always_comb begin
				op = CELL_HOLD;
				lo = (cmd.op == CH_DELETE) ? cmd.pos : '0;
				case (cmd.op)
					CH_INSERT: begin
						if (IDX == cmd.pos)
							op = CELL_NEW;
						else if (IDX > cmd.pos && IDX <= cmd.n)
							op = CELL_LEFT;
					end
					CH_DELETE, CH_ROTATE: begin
						if (IDX >= lo && (IDX + CNT_W'(1)) < cmd.n)
							op = CELL_RIGHT;
						else if (cmd.op == CH_ROTATE && (IDX + CNT_W'(1)) == cmd.n)
							op = CELL_WRAP;
					end
					default: op = CELL_HOLD;
				endcase
			end

			paids_cell u_cell (
				.clk        (clk),
				.op         (op),
				.left_word  (left_w),
				.right_word (right_w),
				.wrap_word  (words[0]),
				.new_word   (cmd.value),
				.key        (cmd.key),
				.word       (words[i]),
				.match      (eq[i])
			);

			// only filled entries may hit
			assign hits[i] = eq[i] && (IDX < cmd.n);
		end
	endgenerate

	assign head_word = words[0];

endmodule

`default_nettype wire

// ----- hw/rtl/paids_find.sv -----
// Registered two-level priority encoder that finds the lowest hit of the chain.
`default_nettype none

module paids_find (
	input  wire                         clk,
	input  wire                         cap,
	input  wire [paids_pkg::DEPTH-1:0]  hits,
	output logic                        hit,
	output logic [paids_pkg::IDX_W-1:0] idx
);
	import paids_pkg::*;

	logic [DEPTH-1:0]    hits_s1;
	logic [NGRP*GRP-1:0] pad;
	logic [GRP_W-1:0]    grp_idx_d [NGRP];
	logic [NGRP-1:0]     grp_hit_s2;
	logic [GRP_W-1:0]    grp_idx_s2 [NGRP];

	// capture compare results of the chain
	always_ff @(posedge clk) begin
		if (cap)
			hits_s1 <= hits;
	end

	genvar k;
	generate
		for (k = 0; k < NGRP * GRP; k++) begin : g_pad
			if (k < DEPTH) begin : g_real
				assign pad[k] = hits_s1[k];
			end else begin : g_fill
				assign pad[k] = 1'b0;
			end
		end
	endgenerate

	// first level: lowest hit within each group
	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_idx_d[g] = '0;
			for (int j = GRP - 1; j >= 0; j--) begin
				if (pad[g*GRP + j])
					grp_idx_d[g] = GRP_W'(j);
			end
		end
	end

	// first level register
	always_ff @(posedge clk) begin
		for (int g = 0; g < NGRP; g++) begin
			grp_hit_s2[g] <= |pad[g*GRP +: GRP];
			grp_idx_s2[g] <= grp_idx_d[g];
		end
	end

	// second level: lowest group with a hit
	always_comb begin
		hit = |grp_hit_s2;
		idx = '0;
		for (int g = NGRP - 1; g >= 0; g--) begin
			if (grp_hit_s2[g])
				idx = IDX_W'(g * GRP) + IDX_W'(grp_idx_s2[g]);
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/positional_array_insert_delete_search_unit.sv -----
// Top level: sequencer, output register, chain of cells and search encoder for the positional array unit.
//
// Keeps up to 64 signed words in a row of cells plus a fill count. One input
// transfer asks for one operation (func on tuser). Clear, insert, delete and
// unused codes finish in the cycle of the transfer: insert and delete shift
// the cells in parallel, and clear only resets the fill count. Search: the
// cells compare against the key, then a two-level registered priority
// encoder picks the lowest hit. Read out of n entries: after the accepting
// cycle the head cell is emitted and the chain rotates by one each cycle the
// output is not held off, so after the last word the array is back in order.
// Results sit in an output register, so the next transfer is taken while the
// result is being read. No clearing pass after reset: entries above the fill
// count are never observed.
`default_nettype none

module positional_array_insert_delete_search_unit (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [71:0] s_axis_tdata,   // position[6:0], value[38:7], key[70:39], zero pad
	input  wire  [2:0]  s_axis_tuser,   // func[2:0]
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [47:0] m_axis_tdata,   // found_index[5:0], data[37:6], count[44:38], zero pad
	output logic [2:0]  m_axis_tuser,   // status[2:0]
	output logic        m_axis_tlast
);
	import paids_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SRCH = 2'd1;
	localparam logic [1:0] ST_FIND = 2'd2;
	localparam logic [1:0] ST_READ = 2'd3;

	logic [1:0]        state_q, state_d;
	logic [CNT_W-1:0]  fill_q, fill_d;
	logic [IDX_W-1:0]  rd_cnt_q, rd_cnt_d;

	logic              ovalid_q;
	logic [STAT_W-1:0] ostatus_q;
	logic [IDX_W-1:0]  oidx_q;
	logic [WORD_W-1:0] odata_q;
	logic [CNT_W-1:0]  ocount_q;
	logic              olast_q;

	logic              load_out;
	logic [STAT_W-1:0] r_status;
	logic [IDX_W-1:0]  r_idx;
	logic [WORD_W-1:0] r_data;
	logic [CNT_W-1:0]  r_count;
	logic              r_last;

	logic              slot_free;
	logic              acc;
	logic              cap;
	logic [FUNC_W-1:0] func;
	logic [CNT_W-1:0]  pos;
	chain_cmd_t        cmd;
	logic [WORD_W-1:0] head_word;
	logic [DEPTH-1:0]  hits;
	logic              f_hit;
	logic [IDX_W-1:0]  f_idx;
	logic              rd_last;

	assign func = s_axis_tuser[2:0];
	assign pos  = s_axis_tdata[6:0];

	assign slot_free     = !ovalid_q || m_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE) && slot_free;
	assign acc           = s_axis_tvalid && s_axis_tready;
	assign rd_last       = ({1'b0, rd_cnt_q} == (fill_q - CNT_W'(1)));

	// sequencer: operation decode, chain command and result
	always_comb begin
		state_d   = state_q;
		fill_d    = fill_q;
		rd_cnt_d  = rd_cnt_q;
		cap       = 1'b0;
		load_out  = 1'b0;
		r_status  = STAT_OK;
		r_idx     = '0;
		r_data    = '0;
		r_count   = fill_q;
		r_last    = 1'b1;
		cmd.op    = CH_NONE;
		cmd.pos   = pos;
		cmd.n     = fill_q;
		cmd.value = s_axis_tdata[38:7];
		cmd.key   = s_axis_tdata[70:39];
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					case (func)
						FN_CLEAR: begin
							load_out = 1'b1;
							fill_d   = '0;
							r_count  = '0;
						end
						FN_INSERT: begin
							load_out = 1'b1;
							if (fill_q == CNT_W'(DEPTH)) begin
								r_status = STAT_FULL;
							end else if (pos > fill_q) begin
								r_status = STAT_BADPOS;
							end else begin
								cmd.op  = CH_INSERT;
								fill_d  = fill_q + CNT_W'(1);
								r_count = fill_q + CNT_W'(1);
							end
						end
						FN_DELETE: begin
							load_out = 1'b1;
							if (fill_q == '0) begin
								r_status = STAT_EMPTY;
							end else if (pos >= fill_q) begin
								r_status = STAT_BADPOS;
							end else begin
								cmd.op  = CH_DELETE;
								fill_d  = fill_q - CNT_W'(1);
								r_count = fill_q - CNT_W'(1);
							end
						end
						FN_SEARCH: begin
							if (fill_q == '0) begin
								load_out = 1'b1;
								r_status = STAT_EMPTY;
							end else begin
								cap     = 1'b1;
								state_d = ST_SRCH;
							end
						end
						FN_READ: begin
							if (fill_q == '0) begin
								load_out = 1'b1;
								r_status = STAT_EMPTY;
							end else begin
								rd_cnt_d = '0;
								state_d  = ST_READ;
							end
						end
						default: load_out = 1'b1;
					endcase
				end
			end
			ST_SRCH: state_d = ST_FIND;
			ST_FIND: begin
				if (slot_free) begin
					load_out = 1'b1;
					r_status = f_hit ? STAT_OK : STAT_NOTFOUND;
					r_idx    = f_hit ? f_idx : '0;
					state_d  = ST_IDLE;
				end
			end
			ST_READ: begin
				if (slot_free) begin
					load_out = 1'b1;
					r_data   = head_word;
					r_last   = rd_last;
					cmd.op   = CH_ROTATE;
					rd_cnt_d = rd_cnt_q + IDX_W'(1);
					if (rd_last)
						state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			fill_q   <= '0;
			rd_cnt_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			fill_q   <= fill_d;
			rd_cnt_q <= rd_cnt_d;
			if (load_out)
				ovalid_q <= 1'b1;
			else if (m_axis_tready)
				ovalid_q <= 1'b0;
		end
	end

	// output payload register
	always_ff @(posedge clk) begin
		if (load_out) begin
			ostatus_q <= r_status;
			oidx_q    <= r_idx;
			odata_q   <= r_data;
			ocount_q  <= r_count;
			olast_q   <= r_last;
		end
	end

	paids_chain u_chain (
		.clk       (clk),
		.cmd       (cmd),
		.head_word (head_word),
		.hits      (hits)
	);

	paids_find u_find (
		.clk  (clk),
		.cap  (cap),
		.hits (hits),
		.hit  (f_hit),
		.idx  (f_idx)
	);

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = {3'b000, ocount_q, odata_q, oidx_q};
	assign m_axis_tuser  = ostatus_q;
	assign m_axis_tlast  = olast_q;

`ifndef SYNTHESIS
	// fill count never passes the array depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(DEPTH))
		else $error("fill count above depth");

	// read out index stays inside the filled range
	a_read_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> ({1'b0, rd_cnt_q} < fill_q))
		else $error("read out index beyond fill count");

	// an accepted clear leaves the array empty
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && func == FN_CLEAR) |=> (fill_q == '0))
		else $error("clear did not empty the array");

	// a search result is only produced after the encoder stage
	a_find_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIND) |-> ($past(state_q) == ST_SRCH || $past(state_q) == ST_FIND))
		else $error("search result without encoder stage");
`endif

endmodule

`default_nettype wire
